// File: hw/rtl/acss_pkg.sv
package acss_pkg;

    localparam int NUM_CHANNELS_DEF = 5;

    localparam int CONV_W   = 10;
    localparam int CH_W     = 3;
    localparam int EN_W     = 5;
    localparam int SETTLE_W = 4;
    localparam int TOTAL_W  = 16;
    localparam int COUNT_W  = 6;
    localparam int CFG_W    = 6;
    localparam int INDEX_W  = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_CHANNEL_ENABLE  = 3'd0,
        REG_DISCARD_COUNT   = 3'd1,
        REG_CURRENT_SAMPLES = 3'd2,
        REG_VOLTAGE_SAMPLES = 3'd3,
        REG_OTHER_SAMPLES   = 3'd4
    } reg_index_t;

    localparam logic [CH_W-1:0] CH_CURRENT = 3'd0;
    localparam logic [CH_W-1:0] CH_VOLTAGE = 3'd1;

    localparam logic [CH_W-1:0] PIN_CURRENT = 3'd1;
    localparam logic [CH_W-1:0] PIN_VOLTAGE = 3'd0;

    localparam logic [EN_W-1:0]     ENABLE_RST  = 5'h3;
    localparam logic [SETTLE_W-1:0] DISCARD_RST = 4'd3;
    localparam logic [COUNT_W-1:0]  CURRENT_RST = 6'd50;
    localparam logic [COUNT_W-1:0]  VOLTAGE_RST = 6'd8;
    localparam logic [COUNT_W-1:0]  OTHER_RST   = 6'd1;

    typedef struct packed {
        logic [EN_W-1:0]     channel_enable;
        logic [SETTLE_W-1:0] discard_count;
        logic [COUNT_W-1:0]  current_samples;
        logic [COUNT_W-1:0]  voltage_samples;
        logic [COUNT_W-1:0]  other_samples;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]    done_channel;
        logic [TOTAL_W-1:0] sum_total;
        logic [COUNT_W-1:0] sum_count;
        logic               queued;
        logic [CH_W-1:0]    next_channel;
        logic [CH_W-1:0]    mux_pin;
    } result_t;

    function automatic logic [CH_W-1:0] chan_pin(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] pin;
        unique case (ch)
            CH_CURRENT: pin = PIN_CURRENT;
            CH_VOLTAGE: pin = PIN_VOLTAGE;
            default:    pin = ch;
        endcase
        return pin;
    endfunction

endpackage

// File: hw/rtl/adc_channel_scan_sequencer.sv
// Channel  Ports                                      Direction
// input    s_valid s_ready s_conv_value               one conversion per beat, in
// result   m_valid m_ready m_done_channel m_sum_total  one finished channel per beat, out
//          m_sum_count m_queued m_next_channel m_mux_pin
// config   cfg_wr_en cfg_index cfg_wdata              register write, in
//
// One conversion beat is taken every cycle while s_ready is high.
// The state update and the round-robin search sit between the input and result registers.
// Reset is synchronous and active low; it restores the register defaults and channel zero.
// A stalled result holds the result register; s_ready drops only when both registers are full.
module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CONV_W-1:0]  s_conv_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CH_W-1:0]    m_done_channel,
    output logic [TOTAL_W-1:0] m_sum_total,
    output logic [COUNT_W-1:0] m_sum_count,
    output logic               m_queued,
    output logic [CH_W-1:0]    m_next_channel,
    output logic [CH_W-1:0]    m_mux_pin
);

    cfg_t    cfg;
    result_t res;
    logic    res_hit;
    logic    advance;

    logic              in_valid_reg, in_valid_next;
    logic [CONV_W-1:0] conv_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    acss_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acss_scan_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_scan_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (advance),
        .conv_value (conv_reg),
        .res_hit    (res_hit),
        .res        (res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && res_hit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            conv_reg <= s_conv_value;
        end
        if (advance && res_hit) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_done_channel = out_reg.done_channel;
    assign m_sum_total    = out_reg.sum_total;
    assign m_sum_count    = out_reg.sum_count;
    assign m_queued       = out_reg.queued;
    assign m_next_channel = out_reg.next_channel;
    assign m_mux_pin      = out_reg.mux_pin;

endmodule

// File: hw/rtl/acss_cfg_regs.sv
module acss_cfg_regs
    import acss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CHANNEL_ENABLE:  cfg_next.channel_enable  = cfg_wdata[EN_W-1:0];
                REG_DISCARD_COUNT:   cfg_next.discard_count   = cfg_wdata[SETTLE_W-1:0];
                REG_CURRENT_SAMPLES: cfg_next.current_samples = cfg_wdata[COUNT_W-1:0];
                REG_VOLTAGE_SAMPLES: cfg_next.voltage_samples = cfg_wdata[COUNT_W-1:0];
                REG_OTHER_SAMPLES:   cfg_next.other_samples   = cfg_wdata[COUNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_enable  <= ENABLE_RST;
            cfg_reg.discard_count   <= DISCARD_RST;
            cfg_reg.current_samples <= CURRENT_RST;
            cfg_reg.voltage_samples <= VOLTAGE_RST;
            cfg_reg.other_samples   <= OTHER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/acss_scan_core.sv
module acss_scan_core
    import acss_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              step,
    input  logic [CONV_W-1:0] conv_value,
    output logic              res_hit,
    output result_t           res
);

    localparam logic [CH_W:0] NUM_CH = (CH_W+1)'(NUM_CHANNELS);

    logic [CH_W-1:0]     active_reg, active_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic [(1<<CH_W)-1:0] enable_ext;
    logic [TOTAL_W-1:0]   sum;
    logic [COUNT_W-1:0]   cnt;
    logic [COUNT_W-1:0]   target;
    logic [CH_W-1:0]      nxt;
    logic                 found;
    logic [CH_W:0]        cand;

    assign enable_ext = {{((1<<CH_W)-EN_W){1'b0}}, cfg.channel_enable};

    // Round-robin search: first enabled channel after the active one, else channel zero.
    always_comb begin
        nxt   = CH_CURRENT;
        found = 1'b0;
        cand  = '0;
        for (int k = 1; k <= NUM_CHANNELS; k++) begin
            cand = {1'b0, active_reg} + (CH_W+1)'(k);
            if (cand >= NUM_CH) begin
                cand = cand - NUM_CH;
            end
            if (!found && enable_ext[cand[CH_W-1:0]]) begin
                found = 1'b1;
                nxt   = cand[CH_W-1:0];
            end
        end
    end

    always_comb begin
        case (active_reg)
            CH_CURRENT: target = cfg.current_samples;
            CH_VOLTAGE: target = cfg.voltage_samples;
            default:    target = cfg.other_samples;
        endcase
    end

    assign sum = total_reg + {{(TOTAL_W-CONV_W){1'b0}}, conv_value};
    assign cnt = count_reg + COUNT_W'(1);

    always_comb begin
        active_next = active_reg;
        settle_next = settle_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        res_hit     = 1'b0;
        if (settle_reg < cfg.discard_count) begin
            settle_next = settle_reg + SETTLE_W'(1);
        end else if (cnt >= target) begin
            res_hit     = 1'b1;
            active_next = nxt;
            settle_next = '0;
            total_next  = '0;
            count_next  = '0;
        end else begin
            total_next = sum;
            count_next = cnt;
        end
    end

    assign res.done_channel = active_reg;
    assign res.sum_total    = sum;
    assign res.sum_count    = cnt;
    assign res.queued       = enable_ext[active_reg];
    assign res.next_channel = nxt;
    assign res.mux_pin      = chan_pin(nxt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= CH_CURRENT;
            settle_reg <= '0;
            total_reg  <= '0;
            count_reg  <= '0;
        end else if (step) begin
            active_reg <= active_next;
            settle_reg <= settle_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: tb/adc_channel_scan_sequencer_tb.sv
`timescale 1ns / 100ps

module adc_channel_scan_sequencer_tb;
    import acss_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int TAIL_ITEMS   = 150;
    localparam int CFG_DRAIN    = 8;
    localparam int END_DRAIN    = 12;
    localparam int CYCLE_LIMIT  = 250000;

    typedef struct packed {
        logic              is_cfg;
        reg_index_t        index;
        logic [CFG_W-1:0]  wdata;
        logic [CONV_W-1:0] conv;
    } stim_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    reg_index_t         cfg_index = REG_CHANNEL_ENABLE;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CONV_W-1:0]  s_conv_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CH_W-1:0]    m_done_channel;
    logic [TOTAL_W-1:0] m_sum_total;
    logic [COUNT_W-1:0] m_sum_count;
    logic               m_queued;
    logic [CH_W-1:0]    m_next_channel;
    logic [CH_W-1:0]    m_mux_pin;

    stim_item_t stim_items[$];
    result_t    due_results[$];

    logic [EN_W-1:0]     mdl_enable  = ENABLE_RST;
    logic [SETTLE_W-1:0] mdl_discard = DISCARD_RST;
    logic [COUNT_W-1:0]  mdl_current = CURRENT_RST;
    logic [COUNT_W-1:0]  mdl_voltage = VOLTAGE_RST;
    logic [COUNT_W-1:0]  mdl_other   = OTHER_RST;
    logic [CH_W-1:0]     mdl_channel = CH_CURRENT;
    logic [SETTLE_W-1:0] mdl_settle  = '0;
    logic [TOTAL_W-1:0]  mdl_sum     = '0;
    logic [COUNT_W-1:0]  mdl_count   = '0;

    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned gap_pct = 20;
    int unsigned beats_sent = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct = 20;
    int unsigned stall_span = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    logic        tail_phase = 1'b0;

    adc_channel_scan_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_conv_value   (s_conv_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_done_channel (m_done_channel),
        .m_sum_total    (m_sum_total),
        .m_sum_count    (m_sum_count),
        .m_queued       (m_queued),
        .m_next_channel (m_next_channel),
        .m_mux_pin      (m_mux_pin)
    );

    function automatic logic chan_enabled(input logic [CH_W-1:0] ch);
        if (ch >= EN_W) begin
            return 1'b0;
        end
        return mdl_enable[ch];
    endfunction

    function automatic logic [COUNT_W-1:0] chan_goal(input logic [CH_W-1:0] ch);
        if (ch == CH_CURRENT) begin
            return mdl_current;
        end
        if (ch == CH_VOLTAGE) begin
            return mdl_voltage;
        end
        return mdl_other;
    endfunction

    function automatic logic [CH_W-1:0] pin_of(input logic [CH_W-1:0] ch);
        if (ch == CH_CURRENT) begin
            return PIN_CURRENT;
        end
        if (ch == CH_VOLTAGE) begin
            return PIN_VOLTAGE;
        end
        return ch;
    endfunction

    function automatic logic [CH_W-1:0] following_channel(input logic [CH_W-1:0] from);
        logic [CH_W-1:0] ch;
        ch = from;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            if (ch + 1 >= NUM_CHANNELS_DEF) begin
                ch = '0;
            end else begin
                ch = ch + 1'b1;
            end
            if (chan_enabled(ch)) begin
                return ch;
            end
        end
        return CH_CURRENT;
    endfunction

    task automatic predict_scan_step(input logic [CONV_W-1:0] conv);
        result_t r;
        if (mdl_settle < mdl_discard) begin
            mdl_settle = mdl_settle + 1'b1;
        end else begin
            mdl_sum   = mdl_sum + conv;
            mdl_count = mdl_count + 1'b1;
            if (mdl_count >= chan_goal(mdl_channel)) begin
                r.done_channel = mdl_channel;
                r.sum_total    = mdl_sum;
                r.sum_count    = mdl_count;
                r.queued       = chan_enabled(mdl_channel);
                r.next_channel = following_channel(mdl_channel);
                r.mux_pin      = pin_of(r.next_channel);
                due_results.push_back(r);
                mdl_channel = r.next_channel;
                mdl_sum     = '0;
                mdl_count   = '0;
                mdl_settle  = '0;
            end
        end
    endtask

    task automatic apply_register(input reg_index_t idx, input logic [CFG_W-1:0] v);
        case (idx)
            REG_CHANNEL_ENABLE:  mdl_enable  = v[EN_W-1:0];
            REG_DISCARD_COUNT:   mdl_discard = v[SETTLE_W-1:0];
            REG_CURRENT_SAMPLES: mdl_current = v[COUNT_W-1:0];
            REG_VOLTAGE_SAMPLES: mdl_voltage = v[COUNT_W-1:0];
            REG_OTHER_SAMPLES:   mdl_other   = v[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_conv(input logic [CONV_W-1:0] v);
        stim_item_t it;
        it.is_cfg = 1'b0;
        it.index  = REG_CHANNEL_ENABLE;
        it.wdata  = '0;
        it.conv   = v;
        stim_items.push_back(it);
    endtask

    task automatic add_write(input reg_index_t idx, input logic [CFG_W-1:0] v);
        stim_item_t it;
        it.is_cfg = 1'b1;
        it.index  = idx;
        it.wdata  = v;
        it.conv   = '0;
        stim_items.push_back(it);
    endtask

    function automatic logic [CONV_W-1:0] rand_conv();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return CONV_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [CFG_W-1:0] rand_goal();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CFG_W'($urandom_range(1, 6));
        end
        if (r < 80) begin
            return CFG_W'(63);
        end
        if (r < 85) begin
            return '0;
        end
        return CFG_W'($urandom_range(7, 62));
    endfunction

    function automatic int unsigned pick_idle_pct();
        int unsigned r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 15;
        end
        return 45;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            error_count++;
        end
    endfunction

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin : drive_proc
        logic              nxt_valid;
        logic [CONV_W-1:0] nxt_conv;
        logic              nxt_wr;
        reg_index_t        nxt_index;
        logic [CFG_W-1:0]  nxt_wdata;
        logic              tail;
        nxt_valid = s_valid;
        nxt_conv  = s_conv_value;
        nxt_wr    = 1'b0;
        nxt_index = cfg_index;
        nxt_wdata = cfg_wdata;
        tail      = stim_items.size() <= TAIL_ITEMS;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_scan_step(s_conv_value);
                nxt_valid    = 1'b0;
                quiet_cycles = 0;
                beats_sent++;
                if (beats_sent % 128 == 0) begin
                    gap_pct = pick_idle_pct();
                end
            end else if (quiet_cycles < CFG_DRAIN) begin
                quiet_cycles++;
            end
            if (!nxt_valid && stim_items.size() > 0) begin
                if (stim_items[0].is_cfg) begin
                    if (due_results.size() == 0 && quiet_cycles >= CFG_DRAIN
                        && !m_valid) begin
                        nxt_wr    = 1'b1;
                        nxt_index = stim_items[0].index;
                        nxt_wdata = stim_items[0].wdata;
                        apply_register(nxt_index, nxt_wdata);
                        stim_items.delete(0);
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (!tail && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 9);
                end else begin
                    nxt_valid = 1'b1;
                    nxt_conv  = stim_items[0].conv;
                    stim_items.delete(0);
                end
            end
        end
        s_valid      <= nxt_valid;
        s_conv_value <= nxt_conv;
        cfg_wr_en    <= nxt_wr;
        cfg_index    <= nxt_index;
        cfg_wdata    <= nxt_wdata;
        tail_phase   <= tail;
    end

    always @(posedge aclk) begin : monitor_proc
        result_t want;
        logic    nxt_ready;
        nxt_ready = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, %s %0d sum %0d count %0d",
                             $time, "actual channel", m_done_channel, m_sum_total,
                             m_sum_count);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("done_channel", want.done_channel, m_done_channel);
                    check_field("sum_total", want.sum_total, m_sum_total);
                    check_field("sum_count", want.sum_count, m_sum_count);
                    check_field("queued", want.queued, m_queued);
                    check_field("next_channel", want.next_channel, m_next_channel);
                    check_field("mux_pin", want.mux_pin, m_mux_pin);
                end
            end
            stall_span++;
            if (stall_span % 256 == 0) begin
                stall_pct = pick_idle_pct();
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 9);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_ready <= nxt_ready;
    end

    initial begin : stimulus_proc
        int unsigned      random_total;
        int unsigned      phase_len;
        int unsigned      r;
        logic [CFG_W-1:0] w;

        // The first two beats are dropped while settling; lowering the discard count
        // then lets the following beats accumulate without a new channel switch.
        add_conv(10'd1023);
        add_conv(10'd0);
        add_write(REG_DISCARD_COUNT, 6'd0);
        add_write(REG_CURRENT_SAMPLES, 6'd2);
        add_write(REG_VOLTAGE_SAMPLES, 6'd1);
        add_write(REG_OTHER_SAMPLES, 6'd1);
        add_write(REG_CHANNEL_ENABLE, 6'h1F);
        add_conv(10'd1023);
        add_conv(10'd1023);
        add_conv(10'd0);
        add_conv(10'd1023);
        add_conv(10'd512);
        add_conv(10'd1);

        // A target lowered under the running count and a disabled active channel.
        add_write(REG_CURRENT_SAMPLES, 6'd3);
        add_conv(10'd300);
        add_conv(10'd301);
        add_write(REG_CURRENT_SAMPLES, 6'd1);
        add_write(REG_CHANNEL_ENABLE, 6'h10);
        add_conv(10'd302);
        add_conv(10'd700);
        add_write(REG_OTHER_SAMPLES, 6'd0);
        add_conv(10'd5);

        // Largest possible sum on the current channel.
        add_write(REG_DISCARD_COUNT, 6'd0);
        add_write(REG_CHANNEL_ENABLE, 6'h01);
        add_write(REG_CURRENT_SAMPLES, 6'd63);
        repeat (130) add_conv(10'd1023);

        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 60) begin
                w = CFG_W'($urandom_range(0, 63));
                if (w[EN_W-1:0] == '0) begin
                    w[EN_W-1:0] = '1;
                end
                add_write(REG_CHANNEL_ENABLE, w);
            end
            if ($urandom_range(0, 99) < 50) begin
                w = CFG_W'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    w[SETTLE_W-1:0] = SETTLE_W'($urandom_range(0, 3));
                end else if (r < 85) begin
                    w[SETTLE_W-1:0] = '1;
                end else begin
                    w[SETTLE_W-1:0] = SETTLE_W'($urandom_range(4, 14));
                end
                add_write(REG_DISCARD_COUNT, w);
            end
            if ($urandom_range(0, 99) < 50) begin
                add_write(REG_CURRENT_SAMPLES, rand_goal());
            end
            if ($urandom_range(0, 99) < 50) begin
                add_write(REG_VOLTAGE_SAMPLES, rand_goal());
            end
            if ($urandom_range(0, 99) < 50) begin
                add_write(REG_OTHER_SAMPLES, rand_goal());
            end
            phase_len = $urandom_range(10, 80);
            repeat (phase_len) add_conv(rand_conv());
            random_total += phase_len;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_items.size() > 0 || s_valid) @(posedge aclk);
        while (due_results.size() > 0) @(posedge aclk);
        repeat (END_DRAIN) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
